// ===== hdl/saabb_pkg.sv =====
// Shared constants, types and helper functions for the swept box collision block.
package saabb_pkg;

   localparam int COORD_BITS     = 16;
   localparam int TIME_FRAC_BITS = 16;
   localparam int TIME_BITS      = 32;

   // Quotient width: edge gap magnitude scaled by the fraction.
   localparam int QUOT_BITS = COORD_BITS + TIME_FRAC_BITS;
   // Internal signed time: quotient, sign and room for the infinities.
   localparam int TW        = QUOT_BITS + 3;
   // Edge gaps need one bit more than a coordinate.
   localparam int GAP_BITS  = COORD_BITS + 1;
   localparam int LANES     = 4;

   localparam logic signed [TW-1:0] T_NEG_INF = {1'b1, {(TW-1){1'b0}}};
   localparam logic signed [TW-1:0] T_POS_INF = {1'b0, {(TW-1){1'b1}}};
   localparam logic signed [TW-1:0] T_ONE     = TW'(1) << TIME_FRAC_BITS;
   localparam logic signed [TW-1:0] T_SAT_LOW = {{(TW-TIME_BITS+1){1'b1}},
                                                 {(TIME_BITS-1){1'b0}}};

   // Lane order in the divider array.
   localparam int LANE_X_IN  = 0;
   localparam int LANE_X_OUT = 1;
   localparam int LANE_Y_IN  = 2;
   localparam int LANE_Y_OUT = 3;

   typedef enum logic [1:0] {
      OUTCOME_NONE  = 2'd0,
      OUTCOME_HIT   = 2'd1,
      OUTCOME_STAND = 2'd2
   } outcome_type;

   // One restoring divider lane: partial remainder, dividend/quotient shifter, divisor.
   typedef struct packed {
      logic [COORD_BITS-1:0] rem;
      logic [QUOT_BITS-1:0]  dq;
      logic [COORD_BITS-1:0] dvs;
   } div_lane_type;

   // Per-request side information carried alongside the dividers.
   typedef struct packed {
      logic             degen;
      logic             x_zero;
      logic             y_zero;
      logic             x_apart;
      logic             y_apart;
      logic             gx_pos;
      logic             gy_pos;
      logic             eq_bot_top;   // moving bottom on static top
      logic             eq_top_bot;   // moving top on static bottom
      logic             eq_right_left;// moving right on static left
      logic             eq_left_right;// moving left on static right
      logic [LANES-1:0] q_neg;
   } meta_type;

   // One quotient bit per call.
   function automatic div_lane_type div_step(input div_lane_type l);
      logic [COORD_BITS:0] shifted;
      logic [COORD_BITS:0] diff;
      div_lane_type        r;
      shifted = {l.rem, l.dq[QUOT_BITS-1]};
      diff    = shifted - {1'b0, l.dvs};
      r.dvs   = l.dvs;
      if (shifted >= {1'b0, l.dvs}) begin
         r.rem = diff[COORD_BITS-1:0];
         r.dq  = {l.dq[QUOT_BITS-2:0], 1'b1};
      end else begin
         r.rem = shifted[COORD_BITS-1:0];
         r.dq  = {l.dq[QUOT_BITS-2:0], 1'b0};
      end
      return r;
   endfunction

   // Start a lane for (-gap << frac) / vel, magnitudes only.
   function automatic div_lane_type div_init(input logic signed [GAP_BITS-1:0] gap,
                                             input logic [COORD_BITS-1:0] vmag);
      logic [GAP_BITS-1:0] gmag;
      div_lane_type        r;
      gmag  = gap[GAP_BITS-1] ? GAP_BITS'(-gap) : GAP_BITS'(gap);
      r.rem = '0;
      r.dq  = {gmag[COORD_BITS-1:0], {TIME_FRAC_BITS{1'b0}}};
      r.dvs = vmag;
      return r;
   endfunction

   // Apply the sign to a finished quotient.
   function automatic logic signed [TW-1:0] quot_signed(input logic [QUOT_BITS-1:0] q,
                                                        input logic neg);
      logic signed [TW-1:0] m;
      m = {{(TW-QUOT_BITS){1'b0}}, q};
      return neg ? -m : m;
   endfunction

endpackage

// ===== hdl/swept_aabb_collision_top.sv =====
// Swept axis-aligned box collision, fully pipelined, one box pair per cycle when not stalled.
//
// Usage:
//   req_* carries one request: a static box, a moving box (signed edges, y
//   grows downward) and the moving box's displacement for the frame.
//   rsp_* returns one result per request, in order: outcome (none, hit,
//   standing overlap), the Q16 entry time saturated low, and the touched
//   sides of the moving box.
//   Both channels are valid/ready; a request moves when valid and ready
//   are high at a rising clock edge.
// Pipeline: 35 register stages (setup, 32 quotient stages, select, output
//   register), the first loaded at the accepting edge.
// Throughput: one request per cycle unless stalled. Four restoring dividers (x entry,
//   x exit, y entry, y exit) each resolve one quotient bit per stage.
// Stall: when rsp_valid is high and rsp_ready low the whole pipeline
//   holds; req_ready drops in that cycle. Bubbles are not squeezed out.
// Reset: synchronous, active high; clears all stage valid bits and
//   rsp_valid. The data registers are not reset.
module swept_aabb_collision_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [saabb_pkg::COORD_BITS-1:0] req_static_left,
   input  logic signed [saabb_pkg::COORD_BITS-1:0] req_static_top,
   input  logic signed [saabb_pkg::COORD_BITS-1:0] req_static_right,
   input  logic signed [saabb_pkg::COORD_BITS-1:0] req_static_bottom,
   input  logic signed [saabb_pkg::COORD_BITS-1:0] req_moving_left,
   input  logic signed [saabb_pkg::COORD_BITS-1:0] req_moving_top,
   input  logic signed [saabb_pkg::COORD_BITS-1:0] req_moving_right,
   input  logic signed [saabb_pkg::COORD_BITS-1:0] req_moving_bottom,
   input  logic signed [saabb_pkg::COORD_BITS-1:0] req_vel_x,
   input  logic signed [saabb_pkg::COORD_BITS-1:0] req_vel_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_outcome,
   output logic signed [saabb_pkg::TIME_BITS-1:0] rsp_entry_time,
   output logic                                  rsp_side_top,
   output logic                                  rsp_side_left,
   output logic                                  rsp_side_bottom,
   output logic                                  rsp_side_right
);
   import saabb_pkg::*;

   localparam int NSTG = QUOT_BITS + 1; // setup stage plus one per quotient bit

   // global advance: the output register is free or being drained
   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // ---------------- setup: edge gaps, zero tests, divider seeds ----------
   logic signed [GAP_BITS-1:0] gxi, gxo, gyi, gyo;
   logic [COORD_BITS-1:0]      vxm, vym;
   logic                       vx_zero, vy_zero;
   meta_type                   meta_in;
   div_lane_type [LANES-1:0]   seed_in;

   always_comb begin
      if (req_vel_x <= 0) begin
         gxi = GAP_BITS'(req_moving_left)  - GAP_BITS'(req_static_right);
         gxo = GAP_BITS'(req_moving_right) - GAP_BITS'(req_static_left);
      end else begin
         gxi = GAP_BITS'(req_moving_right) - GAP_BITS'(req_static_left);
         gxo = GAP_BITS'(req_moving_left)  - GAP_BITS'(req_static_right);
      end
      if (req_vel_y <= 0) begin
         gyi = GAP_BITS'(req_moving_top)    - GAP_BITS'(req_static_bottom);
         gyo = GAP_BITS'(req_moving_bottom) - GAP_BITS'(req_static_top);
      end else begin
         gyi = GAP_BITS'(req_moving_bottom) - GAP_BITS'(req_static_top);
         gyo = GAP_BITS'(req_moving_top)    - GAP_BITS'(req_static_bottom);
      end
      vx_zero = (req_vel_x == 0);
      vy_zero = (req_vel_y == 0);
      vxm = req_vel_x[COORD_BITS-1] ? COORD_BITS'(-req_vel_x) : COORD_BITS'(req_vel_x);
      vym = req_vel_y[COORD_BITS-1] ? COORD_BITS'(-req_vel_y) : COORD_BITS'(req_vel_y);

      seed_in[LANE_X_IN]  = div_init(gxi, vxm);
      seed_in[LANE_X_OUT] = div_init(gxo, vxm);
      seed_in[LANE_Y_IN]  = div_init(gyi, vym);
      seed_in[LANE_Y_OUT] = div_init(gyo, vym);

      // -gap / v is negative when the gap is positive and v nonnegative, or vice versa
      meta_in.q_neg[LANE_X_IN]  = (gxi > 0) != req_vel_x[COORD_BITS-1];
      meta_in.q_neg[LANE_X_OUT] = (gxo > 0) != req_vel_x[COORD_BITS-1];
      meta_in.q_neg[LANE_Y_IN]  = (gyi > 0) != req_vel_y[COORD_BITS-1];
      meta_in.q_neg[LANE_Y_OUT] = (gyo > 0) != req_vel_y[COORD_BITS-1];

      meta_in.degen = ((req_static_left == req_static_right) &&
                       (req_static_top == req_static_bottom)) ||
                      ((req_moving_left == req_moving_right) &&
                       (req_moving_top == req_moving_bottom));
      meta_in.x_zero        = vx_zero;
      meta_in.y_zero        = vy_zero;
      meta_in.x_apart       = (gxi > 0) || (gxo < 0);
      meta_in.y_apart       = (gyi > 0) || (gyo < 0);
      meta_in.gx_pos        = (gxi > 0);
      meta_in.gy_pos        = (gyi > 0);
      meta_in.eq_bot_top    = (req_moving_bottom == req_static_top);
      meta_in.eq_top_bot    = (req_moving_top == req_static_bottom);
      meta_in.eq_right_left = (req_moving_right == req_static_left);
      meta_in.eq_left_right = (req_moving_left == req_static_right);
   end

   // ---------------- divider pipeline ----------------
   // stage 0 holds the seeds; stage k holds k quotient bits
   logic                     vld_ff  [NSTG];
   meta_type                 meta_ff [NSTG];
   div_lane_type [LANES-1:0] lane_ff [NSTG];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
      end
      if (adv) begin
         meta_ff[0] <= meta_in;
         lane_ff[0] <= seed_in;
      end
   end

   for (genvar s = 1; s < NSTG; s++) begin : g_div
      div_lane_type [LANES-1:0] lane_in;
      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            lane_in[l] = div_step(lane_ff[s-1][l]);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= vld_ff[s-1];
         end
         if (adv) begin
            meta_ff[s] <= meta_ff[s-1];
            lane_ff[s] <= lane_in;
         end
      end
   end

   // ---------------- select: signed times, infinities, max/min ----------
   meta_type             m_last;
   logic signed [TW-1:0] xin, xout, yin, yout;
   logic signed [TW-1:0] tin_in, tout_in;
   logic                 xlate_in, stand_in;

   assign m_last = meta_ff[NSTG-1];

   always_comb begin
      if (m_last.x_zero) begin
         xin  = m_last.x_apart ? T_POS_INF : T_NEG_INF;
         xout = m_last.x_apart ? T_NEG_INF : T_POS_INF;
      end else begin
         xin  = quot_signed(lane_ff[NSTG-1][LANE_X_IN].dq,  m_last.q_neg[LANE_X_IN]);
         xout = quot_signed(lane_ff[NSTG-1][LANE_X_OUT].dq, m_last.q_neg[LANE_X_OUT]);
      end
      if (m_last.y_zero) begin
         yin  = m_last.y_apart ? T_POS_INF : T_NEG_INF;
         yout = m_last.y_apart ? T_NEG_INF : T_POS_INF;
      end else begin
         yin  = quot_signed(lane_ff[NSTG-1][LANE_Y_IN].dq,  m_last.q_neg[LANE_Y_IN]);
         yout = quot_signed(lane_ff[NSTG-1][LANE_Y_OUT].dq, m_last.q_neg[LANE_Y_OUT]);
      end
      xlate_in = (xin > yin);
      tin_in   = xlate_in ? xin : yin;
      tout_in  = (xout < yout) ? xout : yout;
      // both axes motionless and overlapping or touching
      stand_in = m_last.x_zero && !m_last.x_apart && m_last.y_zero && !m_last.y_apart;
   end

   logic                 sel_vld_ff;
   meta_type             sel_meta_ff;
   logic signed [TW-1:0] tin_ff, tout_ff;
   logic                 xlate_ff, stand_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_vld_ff <= 1'b0;
      end else if (adv) begin
         sel_vld_ff <= vld_ff[NSTG-1];
      end
      if (adv) begin
         sel_meta_ff <= m_last;
         tin_ff      <= tin_in;
         tout_ff     <= tout_in;
         xlate_ff    <= xlate_in;
         stand_ff    <= stand_in;
      end
   end

   // ---------------- hit test, sides, output register ----------------
   logic                          hit;
   outcome_type                   outcome_in;
   logic signed [TIME_BITS-1:0]   time_in;
   logic                          top_in, left_in, bottom_in, right_in;

   always_comb begin
      hit = !sel_meta_ff.degen && (tin_ff <= tout_ff) &&
            ((tin_ff >= 0) || (tout_ff >= 0)) && (tin_ff <= T_ONE);
      top_in    = 1'b0;
      left_in   = 1'b0;
      bottom_in = 1'b0;
      right_in  = 1'b0;
      outcome_in = OUTCOME_NONE;
      time_in    = '0;
      if (hit) begin
         if (stand_ff) begin
            bottom_in = sel_meta_ff.eq_bot_top;
            top_in    = sel_meta_ff.eq_top_bot;
            right_in  = sel_meta_ff.eq_right_left;
            left_in   = sel_meta_ff.eq_left_right;
         end else if (xlate_ff) begin
            if (sel_meta_ff.eq_bot_top)      bottom_in = 1'b1;
            else if (sel_meta_ff.eq_top_bot) top_in    = 1'b1;
            else if (sel_meta_ff.gx_pos)     left_in   = 1'b1;
            else                             right_in  = 1'b1;
         end else begin
            if (sel_meta_ff.eq_right_left)      right_in  = 1'b1;
            else if (sel_meta_ff.eq_left_right) left_in   = 1'b1;
            else if (sel_meta_ff.gy_pos)        top_in    = 1'b1;
            else                                bottom_in = 1'b1;
         end
         outcome_in = (tin_ff == T_NEG_INF) ? OUTCOME_STAND : OUTCOME_HIT;
         // minus infinity saturates too
         time_in = (tin_ff < T_SAT_LOW) ? T_SAT_LOW[TIME_BITS-1:0]
                                        : tin_ff[TIME_BITS-1:0];
      end
   end

   logic                        rsp_valid_ff;
   outcome_type                 outcome_ff;
   logic signed [TIME_BITS-1:0] time_ff;
   logic                        top_ff, left_ff, bottom_ff, right_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= sel_vld_ff;
      end
      if (adv) begin
         outcome_ff <= outcome_in;
         time_ff    <= time_in;
         top_ff     <= top_in;
         left_ff    <= left_in;
         bottom_ff  <= bottom_in;
         right_ff   <= right_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_outcome     = outcome_ff;
   assign rsp_entry_time  = time_ff;
   assign rsp_side_top    = top_ff;
   assign rsp_side_left   = left_ff;
   assign rsp_side_bottom = bottom_ff;
   assign rsp_side_right  = right_ff;

endmodule

// ===== bench/tb.sv =====
// Testbench for the swept box collision block: directed table, then random requests.
`timescale 1ns / 100ps

module tb;
   import saabb_pkg::*;

   localparam int N_RANDOM   = 1425;
   localparam int QUIET_TAIL = 200;   // last requests run with no idling
   localparam int PIPE_DEPTH = 34;    // used for the settling wait after the final drain

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct {
      coord_type sl, st, sr, sb, ml, mt, mr, mb, vx, vy;
   } box_pair_type;

   typedef struct {
      outcome_type               outcome;
      logic signed [TIME_BITS-1:0] entry_time;
      logic top, left, bottom, right;
   } contact_type;

   // One directed row; typed marks a row whose result is written out by hand.
   typedef struct {
      box_pair_type p;
      bit           typed;
      contact_type  res;
   } row_type;

   localparam longint NEG_INF = 64'sh8000_0000_0000_0000;
   localparam longint POS_INF = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint ONE_Q   = 64'sd1 << TIME_FRAC_BITS;

   logic   clock = 1'b0;
   logic   reset = 1'b1;
   logic   req_valid = 1'b0;
   logic   req_ready;
   coord_type req_static_left = '0, req_static_top = '0, req_static_right = '0;
   coord_type req_static_bottom = '0, req_moving_left = '0, req_moving_top = '0;
   coord_type req_moving_right = '0, req_moving_bottom = '0, req_vel_x = '0, req_vel_y = '0;
   logic   rsp_valid;
   logic   rsp_ready = 1'b0;
   logic [1:0] rsp_outcome;
   logic signed [TIME_BITS-1:0] rsp_entry_time;
   logic   rsp_side_top, rsp_side_left, rsp_side_bottom, rsp_side_right;

   contact_type pending_q[$];   // expected contacts, oldest first
   int  mismatches = 0;
   int  unexpected = 0;
   int  n_hit = 0, n_stand = 0, n_miss = 0, n_sat = 0, n_checked = 0;
   bit  quiet = 1'b0;        // no idling on either side
   bit  sender_idle_ok = 1'b1;

   swept_aabb_collision_top dut (
      .clock, .reset, .req_valid, .req_ready,
      .req_static_left, .req_static_top, .req_static_right, .req_static_bottom,
      .req_moving_left, .req_moving_top, .req_moving_right, .req_moving_bottom,
      .req_vel_x, .req_vel_y,
      .rsp_valid, .rsp_ready, .rsp_outcome, .rsp_entry_time,
      .rsp_side_top, .rsp_side_left, .rsp_side_bottom, .rsp_side_right
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Per-axis sweep: entry gap, entry and exit times in Q16 (or the infinities).
   function automatic void sweep(input longint s_lo, s_hi, m_lo, m_hi, v,
                                 output longint gap_in, t_in, t_out);
      longint g_out;
      gap_in = (v <= 0) ? m_lo - s_hi : m_hi - s_lo;
      g_out  = (v <= 0) ? m_hi - s_lo : m_lo - s_hi;
      if (v == 0) begin
         if (gap_in > 0 || g_out < 0) begin
            t_in = POS_INF; t_out = NEG_INF;
         end else begin
            t_in = NEG_INF; t_out = POS_INF;
         end
      end else begin
         // signed longint division truncates toward zero
         t_in  = (-gap_in * ONE_Q) / v;
         t_out = (-g_out * ONE_Q) / v;
      end
   endfunction

   function automatic contact_type predict_contact(input box_pair_type p);
      contact_type c;
      longint sl, st, sr, sb, ml, mt, mr, mb;
      longint gx, gy, xin, xout, yin, yout, t_in, t_out;
      sl = p.sl; st = p.st; sr = p.sr; sb = p.sb;
      ml = p.ml; mt = p.mt; mr = p.mr; mb = p.mb;
      c = '{OUTCOME_NONE, '0, 1'b0, 1'b0, 1'b0, 1'b0};
      // a point-sized box never collides
      if ((sl == sr && st == sb) || (ml == mr && mt == mb))
         return c;
      sweep(sl, sr, ml, mr, longint'(p.vx), gx, xin, xout);
      sweep(st, sb, mt, mb, longint'(p.vy), gy, yin, yout);
      t_in  = (xin > yin) ? xin : yin;
      t_out = (xout < yout) ? xout : yout;
      if (!(t_in <= t_out && (t_in >= 0 || t_out >= 0) && t_in <= ONE_Q))
         return c;
      if (xin == NEG_INF && yin == NEG_INF) begin
         c.bottom = (mb == st);
         c.top    = (mt == sb);
         c.right  = (mr == sl);
         c.left   = (ml == sr);
      end else if (xin > yin) begin
         if (mb == st)      c.bottom = 1'b1;
         else if (mt == sb) c.top    = 1'b1;
         else if (gx > 0)   c.left   = 1'b1;
         else               c.right  = 1'b1;
      end else begin
         if (mr == sl)      c.right  = 1'b1;
         else if (ml == sr) c.left   = 1'b1;
         else if (gy > 0)   c.top    = 1'b1;
         else               c.bottom = 1'b1;
      end
      if (t_in == NEG_INF) begin
         c.outcome    = OUTCOME_STAND;
         c.entry_time = 32'sh8000_0000;
      end else begin
         c.outcome    = OUTCOME_HIT;
         c.entry_time = (t_in < -(64'sd1 << 31)) ? 32'sh8000_0000 : t_in[31:0];
      end
      return c;
   endfunction

   function automatic coord_type pick(input int lo, input int hi);
      return coord_type'($urandom_range(hi - lo) + lo);
   endfunction

   // Mostly nearby boxes with small random velocities; some full-range noise.
   function automatic box_pair_type random_pair();
      box_pair_type p;
      int base_x, base_y, r;
      r = $urandom_range(9);
      if (r == 0) begin
         p = '{coord_type'($urandom), coord_type'($urandom), coord_type'($urandom),
               coord_type'($urandom), coord_type'($urandom), coord_type'($urandom),
               coord_type'($urandom), coord_type'($urandom), coord_type'($urandom),
               coord_type'($urandom)};
         return p;
      end
      base_x = $urandom_range(60000) - 30000;
      base_y = $urandom_range(60000) - 30000;
      p.sl = coord_type'(base_x);
      p.st = coord_type'(base_y);
      p.sr = coord_type'(base_x + $urandom_range(200));
      p.sb = coord_type'(base_y + $urandom_range(200));
      p.ml = coord_type'(base_x + $urandom_range(800) - 400);
      p.mt = coord_type'(base_y + $urandom_range(800) - 400);
      p.mr = coord_type'(p.ml + $urandom_range(200));
      p.mb = coord_type'(p.mt + $urandom_range(200));
      // snap edges onto each other now and then to hit the side rules
      case ($urandom_range(7))
         0: begin p.ml = p.sr; p.mr = coord_type'(p.ml + $urandom_range(100)); end
         1: begin p.mr = p.sl; p.ml = coord_type'(p.mr - $urandom_range(100)); end
         2: begin p.mt = p.sb; p.mb = coord_type'(p.mt + $urandom_range(100)); end
         3: begin p.mb = p.st; p.mt = coord_type'(p.mb - $urandom_range(100)); end
         default: ;
      endcase
      p.vx = ($urandom_range(5) == 0) ? coord_type'(0) : pick(-900, 900);
      p.vy = ($urandom_range(5) == 0) ? coord_type'(0) : pick(-900, 900);
      if ($urandom_range(15) == 0) p.vx = pick(-32768, 32767);
      if ($urandom_range(15) == 0) p.vy = pick(-32768, 32767);
      return p;
   endfunction

   // Drive one request and hold it until accepted; then maybe idle the sender.
   task automatic send_request(input box_pair_type p, input contact_type exp_c);
      req_static_left   <= p.sl; req_static_top    <= p.st;
      req_static_right  <= p.sr; req_static_bottom <= p.sb;
      req_moving_left   <= p.ml; req_moving_top    <= p.mt;
      req_moving_right  <= p.mr; req_moving_bottom <= p.mb;
      req_vel_x <= p.vx; req_vel_y <= p.vy;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_q.push_back(exp_c);
      if (!quiet && sender_idle_ok && $urandom_range(5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(7, 1)) @(posedge clock);
      end
   endtask

   task automatic drain();
      while (pending_q.size() != 0) @(posedge clock);
   endtask

   // Receiver stalls come in bursts.
   int stall_left = 0;
   always @(posedge clock) begin
      if (quiet || reset) begin
         rsp_ready <= !reset;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(7) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(6);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Result check against the oldest expectation.
   always @(posedge clock) begin
      contact_type e;
      bit bad;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_q.size() == 0) begin
            unexpected++;
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result with nothing expected, outcome %0d time %0d",
                        rsp_outcome, rsp_entry_time);
         end else begin
            e = pending_q.pop_front();
            n_checked++;
            bad = (rsp_outcome !== e.outcome) || (rsp_entry_time !== e.entry_time) ||
                  (rsp_side_top !== e.top) || (rsp_side_left !== e.left) ||
                  (rsp_side_bottom !== e.bottom) || (rsp_side_right !== e.right);
            if (bad) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("ERROR: result %0d exp oc=%0d t=%0d tlbr=%b%b%b%b",
                           n_checked, e.outcome, e.entry_time, e.top, e.left,
                           e.bottom, e.right);
                  $display("       got oc=%0d t=%0d tlbr=%b%b%b%b",
                           rsp_outcome, rsp_entry_time, rsp_side_top,
                           rsp_side_left, rsp_side_bottom, rsp_side_right);
               end
            end
            case (e.outcome)
               OUTCOME_HIT:   n_hit++;
               OUTCOME_STAND: n_stand++;
               default:       n_miss++;
            endcase
            if (e.outcome == OUTCOME_HIT && e.entry_time == 32'sh8000_0000) n_sat++;
         end
      end
   end

   initial begin
      row_type      rows[$];
      box_pair_type p;
      contact_type  c;
      contact_type  no_res;
      coord_type    mn, mx;
      mn = coord_type'(16'h8000);
      mx = coord_type'(16'h7FFF);
      no_res = '{OUTCOME_NONE, 0, 0, 0, 0, 0};

      // Directed rows: static l,t,r,b | moving l,t,r,b | vx,vy
      // degenerate static box
      rows.push_back('{'{5, 5, 5, 5, 0, 0, 10, 10, 1, 1}, 1,
                       '{OUTCOME_NONE, 0, 0, 0, 0, 0}});
      // degenerate moving box
      rows.push_back('{'{0, 0, 10, 10, 3, 3, 3, 3, 0, 0}, 1,
                       '{OUTCOME_NONE, 0, 0, 0, 0, 0}});
      // apart with no motion
      rows.push_back('{'{0, 0, 10, 10, 20, 20, 30, 30, 0, 0}, 1,
                       '{OUTCOME_NONE, 0, 0, 0, 0, 0}});
      // standing overlap, touching on the static left side only
      rows.push_back('{'{10, 0, 20, 10, 0, 0, 10, 10, 0, 0}, 1,
                       '{OUTCOME_STAND, 32'sh8000_0000, 0, 0, 0, 1}});
      // standing overlap, inside
      rows.push_back('{'{0, 0, 100, 100, 10, 10, 20, 20, 0, 0}, 1,
                       '{OUTCOME_STAND, 32'sh8000_0000, 0, 0, 0, 0}});
      // hit halfway, moving right into the left side
      rows.push_back('{'{10, 0, 20, 10, 0, 0, 5, 10, 10, 0}, 1,
                       '{OUTCOME_HIT, 32768, 0, 0, 0, 1}});
      // moving away, no hit
      rows.push_back('{'{10, 0, 20, 10, 0, 0, 5, 10, -10, 0}, 1,
                       '{OUTCOME_NONE, 0, 0, 0, 0, 0}});
      // predictor-checked rows from here
      rows.push_back('{'{10, 0, 20, 10, 0, 0, 5, 10, 5, 0}, 0, no_res});   // entry at 1.0
      rows.push_back('{'{10, 0, 20, 10, 0, 0, 5, 10, 4, 0}, 0, no_res});   // just short
      rows.push_back('{'{0, 10, 10, 20, 0, 0, 10, 4, 0, 7}, 0, no_res});   // moving down
      rows.push_back('{'{0, 0, 10, 10, 0, 20, 10, 30, 0, -13}, 0, no_res}); // moving up
      rows.push_back('{'{0, 0, 10, 10, 20, 0, 30, 10, -11, 0}, 0, no_res}); // moving left
      rows.push_back('{'{0, 0, 10, 10, 15, 15, 25, 25, -9, -7}, 0, no_res}); // diagonal
      rows.push_back('{'{0, 0, 10, 10, 5, 5, 15, 15, 3, 3}, 0, no_res});   // already overlapping
      rows.push_back('{'{20, 0, 10, 10, 0, 0, 5, 10, 10, 0}, 0, no_res});  // inverted static
      rows.push_back('{'{10, 0, 20, 10, 5, 10, 0, 0, 10, 0}, 0, no_res});  // inverted moving
      rows.push_back('{'{mn, 0, 100, 10, mn, 0, mx, 10, 1, 0}, 0, no_res}); // huge negative entry
      rows.push_back('{'{mn, mn, mx, mx, mn, mn, mx, mx, mx, mn}, 0, no_res}); // extremes
      rows.push_back('{'{mx, mx, mn, mn, mx, mn, mn, mx, mn, mx}, 0, no_res});
      rows.push_back('{'{-1, -1, 1, 1, -100, -100, -98, -98, 1, 1}, 0, no_res});
      rows.push_back('{'{mn, mn, mn, mx, mx, mx, mx, mn, -1, mn}, 0, no_res});
      rows.push_back('{'{0, 0, 10, 10, 10, 10, 20, 20, 0, 0}, 0, no_res}); // corner touch

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         send_request(rows[i].p, rows[i].typed ? rows[i].res : predict_contact(rows[i].p));

      // hold off the sender until the pipeline is empty
      req_valid <= 1'b0;
      drain();

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 2) begin
            req_valid <= 1'b0;
            drain();
         end
         if (i == N_RANDOM - QUIET_TAIL) quiet = 1'b1;
         p = random_pair();
         c = predict_contact(p);
         send_request(p, c);
      end
      req_valid <= 1'b0;

      drain();
      repeat (PIPE_DEPTH + 10) @(posedge clock);

      $display("Checked %0d results: %0d hits (%0d saturated), %0d standing, %0d misses.",
               n_checked, n_hit, n_sat, n_stand, n_miss);
      $display("Directed edge cases plus random sweeps, with bursty stalls on both sides.");
      if (mismatches == 0 && pending_q.size() == 0) begin
         $display("** swept_aabb_collision_top: PASSED **");
      end else begin
         $display("%0d mismatches, %0d unexpected, %0d never arrived",
                  mismatches, unexpected, pending_q.size());
         $display("** swept_aabb_collision_top: FAILED **");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("ERROR: timeout");
      $display("** swept_aabb_collision_top: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/saabb_pkg.sv
hdl/swept_aabb_collision_top.sv
bench/tb.sv
